>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers for the checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also covers the reset cycles.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/lfpt_pkg.sv
// ---------------------------------------------------------------------------
// lfpt_pkg
// Shared constants, codes and queue entry type of the LED flash timer.
// ---------------------------------------------------------------------------
package lfpt_pkg;

  localparam int LED_COUNT_DEF   = 8;
  localparam int TICK_MS_DEF     = 10;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int MASK_W          = 8;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_ON    = 2'd1;
  localparam logic [1:0] CMD_OFF   = 2'd2;
  localparam logic [1:0] CMD_FLASH = 2'd3;

  // timer phase codes
  localparam logic [1:0] PH_UNDEF = 2'd0;
  localparam logic [1:0] PH_ON    = 2'd1;
  localparam logic [1:0] PH_OFF   = 2'd2;
  localparam logic [1:0] PH_PAUSE = 2'd3;

  // item class set by the front end
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_LED  = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  command;
    logic [3:0]  led_index;
    logic [15:0] on_time_ms;
    logic [15:0] off_time_ms;
    logic [7:0]  cycle_limit;
    logic [15:0] repeat_delay_ms;
  } lfpt_item_t;

endpackage

>>> hw/rtl/led_flash_pattern_timer.sv
// ---------------------------------------------------------------------------
// led_flash_pattern_timer
// Per-LED blink timers driven by tick and LED commands; reports the lit mask.
// ---------------------------------------------------------------------------
// channel  | direction | handshake         | payload
// command  | in        | push / full       | command, led_number, times, limits
// result   | out       | pop / empty       | lit_mask, status
//
// A tick walks one LED entry per cycle in the execute state.
// Steady on/off, flash and bad LED numbers go through the execute state once.
// The input stage register and the command queue lie ahead of the engine.
// Reset is synchronous; all timers clear, all LEDs go dark.
// The engine holds the next command while the result register is unread.
// ---------------------------------------------------------------------------
module led_flash_pattern_timer #(
  parameter int LED_COUNT   = lfpt_pkg::LED_COUNT_DEF,
  parameter int TICK_MS     = lfpt_pkg::TICK_MS_DEF,
  parameter int QUEUE_DEPTH = lfpt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command,
  input  logic [3:0]  led_number,
  input  logic [15:0] on_time_ms,
  input  logic [15:0] off_time_ms,
  input  logic [7:0]  cycle_limit,
  input  logic [15:0] repeat_delay_ms,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  lit_mask,
  output logic        status
);
  import lfpt_pkg::*;

  logic       q_wr;
  logic       q_full;
  logic       q_rd;
  logic       q_empty;
  lfpt_item_t q_wr_data;
  lfpt_item_t q_rd_data;

  lfpt_front #(
    .LED_COUNT(LED_COUNT)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .command         (command),
    .led_number      (led_number),
    .on_time_ms      (on_time_ms),
    .off_time_ms     (off_time_ms),
    .cycle_limit     (cycle_limit),
    .repeat_delay_ms (repeat_delay_ms),
    .q_wr            (q_wr),
    .q_full          (q_full),
    .q_data          (q_wr_data)
  );

  lfpt_cmd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .full    (q_full),
    .wr_data (q_wr_data),
    .rd_en   (q_rd),
    .empty   (q_empty),
    .rd_data (q_rd_data)
  );

  lfpt_engine #(
    .LED_COUNT(LED_COUNT),
    .TICK_MS  (TICK_MS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_rd     (q_rd),
    .q_data   (q_rd_data),
    .empty    (empty),
    .pop      (pop),
    .lit_mask (lit_mask),
    .status   (status)
  );

endmodule

>>> hw/rtl/lfpt_front.sv
// ---------------------------------------------------------------------------
// lfpt_front
// Input stage: takes a beat, classifies it and hands it to the command queue.
// ---------------------------------------------------------------------------
module lfpt_front #(
  parameter int LED_COUNT = lfpt_pkg::LED_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          command,
  input  logic [3:0]          led_number,
  input  logic [15:0]         on_time_ms,
  input  logic [15:0]         off_time_ms,
  input  logic [7:0]          cycle_limit,
  input  logic [15:0]         repeat_delay_ms,
  output logic                q_wr,
  input  logic                q_full,
  output lfpt_pkg::lfpt_item_t q_data
);
  import lfpt_pkg::*;

  logic       hold_valid;
  logic       accept;
  lfpt_item_t item_next;

  assign full   = hold_valid && q_full;
  assign accept = push && !full;
  assign q_wr   = hold_valid && !q_full;

  always_comb begin
    item_next.command         = command;
    item_next.led_index       = led_number - 4'd1;
    item_next.on_time_ms      = on_time_ms;
    item_next.off_time_ms     = off_time_ms;
    item_next.cycle_limit     = cycle_limit;
    item_next.repeat_delay_ms = repeat_delay_ms;
    if (command == CMD_TICK) begin
      item_next.kind = KIND_TICK;
    end else if (led_number != 4'd0 && 5'(led_number) <= 5'(LED_COUNT)) begin
      item_next.kind = KIND_LED;
    end else begin
      item_next.kind = KIND_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (q_wr) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_data <= item_next;
    end
  end

endmodule

>>> hw/rtl/lfpt_cmd_fifo.sv
// ---------------------------------------------------------------------------
// lfpt_cmd_fifo
// Short command queue between the front end and the timer engine.
// ---------------------------------------------------------------------------
module lfpt_cmd_fifo #(
  parameter int DEPTH = lfpt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  output logic                 full,
  input  lfpt_pkg::lfpt_item_t wr_data,
  input  logic                 rd_en,
  output logic                 empty,
  output lfpt_pkg::lfpt_item_t rd_data
);
  import lfpt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lfpt_item_t        entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> hw/rtl/lfpt_engine.sv
// ---------------------------------------------------------------------------
// lfpt_engine
// Back end: per-LED timer state, tick walk, commands and result register.
// ---------------------------------------------------------------------------
module lfpt_engine #(
  parameter int LED_COUNT = lfpt_pkg::LED_COUNT_DEF,
  parameter int TICK_MS   = lfpt_pkg::TICK_MS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  output logic                       q_rd,
  input  lfpt_pkg::lfpt_item_t       q_data,
  output logic                       empty,
  input  logic                       pop,
  output logic [lfpt_pkg::MASK_W-1:0] lit_mask,
  output logic                       status
);
  import lfpt_pkg::*;

  localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [15:0] TICK16 = 16'(TICK_MS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  phase        [LED_COUNT];
  logic [15:0] remaining_ms [LED_COUNT];
  logic [15:0] on_period    [LED_COUNT];
  logic [15:0] off_period   [LED_COUNT];
  logic [7:0]  burst_length [LED_COUNT];
  logic [7:0]  burst_count  [LED_COUNT];
  logic [15:0] pause_period [LED_COUNT];
  logic [LED_COUNT-1:0] lit;

  logic [1:0]       state;
  lfpt_item_t       cur;
  logic [IDX_W-1:0] walk_idx;
  logic [IDX_W-1:0] sel;
  logic             walk_last;
  logic             wr_en;
  logic             out_valid;
  logic [MASK_W-1:0] mask_now;

  logic [1:0]  r_phase, n_phase;
  logic [15:0] r_rem, n_rem;
  logic [15:0] r_on, n_on;
  logic [15:0] r_off, n_off;
  logic [7:0]  r_blen, n_blen;
  logic [7:0]  r_bcnt, n_bcnt;
  logic [15:0] r_pause, n_pause;
  logic        n_lit;
  logic [7:0]  cnt_inc;

  assign empty     = !out_valid;
  assign q_rd      = (state == ST_IDLE) && !q_empty && !out_valid;
  assign sel       = (cur.kind == KIND_TICK) ? walk_idx : cur.led_index[IDX_W-1:0];
  assign walk_last = (walk_idx == IDX_W'(LED_COUNT - 1));
  assign wr_en     = (state == ST_EXEC) && (cur.kind != KIND_BAD);

  assign r_phase = phase[sel];
  assign r_rem   = remaining_ms[sel];
  assign r_on    = on_period[sel];
  assign r_off   = off_period[sel];
  assign r_blen  = burst_length[sel];
  assign r_bcnt  = burst_count[sel];
  assign r_pause = pause_period[sel];
  assign cnt_inc = r_bcnt + 8'd1;

  always_comb begin
    n_phase = r_phase;
    n_rem   = r_rem;
    n_on    = r_on;
    n_off   = r_off;
    n_blen  = r_blen;
    n_bcnt  = r_bcnt;
    n_pause = r_pause;
    n_lit   = lit[sel];
    if (cur.kind == KIND_TICK) begin
      if (r_rem > TICK16) begin
        n_rem = r_rem - TICK16;
      end else if (r_rem != 16'd0) begin
        case (r_phase)
          PH_ON: begin
            n_lit   = 1'b0;
            n_phase = PH_OFF;
            n_rem   = r_off;
            if (r_blen != 8'd0) begin
              n_bcnt = cnt_inc;
              if (cnt_inc == r_blen) begin
                if (r_pause != 16'd0) begin
                  n_phase = PH_PAUSE;
                  n_rem   = r_pause;
                end else begin
                  n_rem = 16'd0;
                end
              end
            end
          end
          PH_OFF: begin
            n_lit   = 1'b1;
            n_phase = PH_ON;
            n_rem   = r_on;
          end
          PH_PAUSE: begin
            n_lit   = 1'b1;
            n_phase = PH_ON;
            n_rem   = r_on;
            n_bcnt  = 8'd0;
          end
          default: begin
            // expiry with no phase set: timer holds
          end
        endcase
      end
    end else begin
      n_rem  = 16'd0;
      n_bcnt = 8'd0;
      case (cur.command)
        CMD_ON: begin
          n_phase = PH_ON;
          n_pause = 16'd0;
          n_lit   = 1'b1;
        end
        CMD_OFF: begin
          n_phase = PH_OFF;
          n_pause = 16'd0;
          n_lit   = 1'b0;
        end
        CMD_FLASH: begin
          n_phase = PH_ON;
          n_on    = cur.on_time_ms;
          n_off   = cur.off_time_ms;
          n_blen  = cur.cycle_limit;
          n_pause = cur.repeat_delay_ms;
          n_rem   = cur.on_time_ms;
          n_lit   = 1'b1;
        end
        default: begin
          // tick never reaches this branch
        end
      endcase
    end
  end

  // only the first eight LEDs are visible in the mask
  for (genvar g = 0; g < MASK_W; g++) begin : g_mask
    if (g < LED_COUNT) begin : g_led
      assign mask_now[g] = lit[g];
    end else begin : g_none
      assign mask_now[g] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        phase[i]        <= PH_UNDEF;
        remaining_ms[i] <= '0;
        on_period[i]    <= '0;
        off_period[i]   <= '0;
        burst_length[i] <= '0;
        burst_count[i]  <= '0;
        pause_period[i] <= '0;
      end
      lit <= '0;
    end else if (wr_en) begin
      phase[sel]        <= n_phase;
      remaining_ms[sel] <= n_rem;
      on_period[sel]    <= n_on;
      off_period[sel]   <= n_off;
      burst_length[sel] <= n_blen;
      burst_count[sel]  <= n_bcnt;
      pause_period[sel] <= n_pause;
      lit[sel]          <= n_lit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      walk_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          walk_idx <= '0;
          if (q_rd) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cur.kind != KIND_TICK || walk_last) begin
            state <= ST_DONE;
          end else begin
            walk_idx <= walk_idx + IDX_W'(1);
          end
        end
        ST_DONE: begin
          // result register is free here: an item starts only when it is
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
    if (state == ST_DONE) begin
      lit_mask <= mask_now;
      status   <= (cur.kind == KIND_BAD);
    end
  end

endmodule

>>> hw/rtl/lfpt_checker.sv
// ---------------------------------------------------------------------------
// lfpt_checker
// Port-level checks on the LED flash timer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lfpt_checker #(
  parameter int LED_COUNT = lfpt_pkg::LED_COUNT_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] lit_mask,
  input logic       status
);

  logic [7:0] pending;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = push && !full;
  assign out_beat = pop && !empty;

  // commands taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 8'(in_beat) - 8'(out_beat);
    end
  end

  `ASSERT_CLK_ALWAYS(a_reset_clears, clk, rst |=> (empty && !full), "reset left a beat pending")
  `ASSERT_CLK(a_result_holds, clk, rst, (!empty && !pop) |=> (!empty && $stable(lit_mask) && $stable(status)), "waiting result changed")
  `ASSERT_CLK(a_no_invented, clk, rst, !empty |-> (pending != 8'd0), "result without a command")
  `ASSERT_CLK(a_drains, clk, rst, (out_beat && pending == 8'd1 && !in_beat) |=> empty, "extra result after last command")
  `ASSERT_CLK(a_mask_range, clk, rst, !empty |-> ((LED_COUNT >= 8) || ((lit_mask >> LED_COUNT) == 8'd0)), "mask bit set for missing LED")

endmodule

bind led_flash_pattern_timer lfpt_checker #(.LED_COUNT(LED_COUNT)) u_lfpt_checker (.*);

>>> verif/led_flash_pattern_timer_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// led_flash_pattern_timer_tb
// Self-checking bench for the LED flash timer. A directed table covers the
// error codes, field extremes and a full burst and pause cycle. Random
// commands follow under three idle mixes and a forced receiver stall. Every
// result beat is checked against a per-LED timer model or a typed-in result.
// ---------------------------------------------------------------------------
module led_flash_pattern_timer_tb;
  import lfpt_pkg::*;

  localparam int LED_COUNT   = LED_COUNT_DEF;
  localparam int TICK_MS     = TICK_MS_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 20;
  localparam int N_DIR       = 24;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  led_number;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [7:0]  cycles;
    logic [15:0] delay_ms;
    logic        fixed;      // expected result typed in below
    logic [7:0]  fixed_mask;
    logic        fixed_status;
  } led_cmd_row_t;

  typedef struct packed {
    logic [7:0] mask;
    logic       status;
  } lit_result_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [15:0] remaining;
    logic [15:0] on_p;
    logic [15:0] off_p;
    logic [7:0]  burst_len;
    logic [7:0]  burst_cnt;
    logic [15:0] pause_p;
    logic        lit;
  } led_timer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  command = CMD_TICK;
  logic [3:0]  led_number = '0;
  logic [15:0] on_time_ms = '0;
  logic [15:0] off_time_ms = '0;
  logic [7:0]  cycle_limit = '0;
  logic [15:0] repeat_delay_ms = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  lit_mask;
  logic        status;

  led_timer_t  timers [LED_COUNT] = '{default: '0};
  lit_result_t lit_exp_q [$];
  lit_result_t lit_exp;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int errors        = 0;
  int cycle_count   = 0;
  int beats_checked = 0;
  int n_ticks       = 0;
  int n_flash       = 0;
  int n_reject      = 0;
  int n_cmds        = 0;

  led_cmd_row_t dir_rows [N_DIR] = '{
    // cmd        led    on         off        cyc     delay      fixed mask    st
    '{CMD_TICK,  4'd15, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 8'h00, 1'b0},
    '{CMD_ON,    4'd0,  16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1, 8'h00, 1'b1},
    '{CMD_OFF,   4'd9,  16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1, 8'h00, 1'b1},
    '{CMD_FLASH, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 8'h00, 1'b1},
    '{CMD_ON,    4'd1,  16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1, 8'h01, 1'b0},
    '{CMD_ON,    4'd8,  16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 8'h81, 1'b0},
    '{CMD_OFF,   4'd1,  16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1, 8'h80, 1'b0},
    '{CMD_FLASH, 4'd2,  16'h0000, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 8'h82, 1'b0},
    '{CMD_TICK,  4'd0,  16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1, 8'h82, 1'b0},
    '{CMD_FLASH, 4'd3,  16'd10,   16'd0,    8'd0,  16'd0,    1'b1, 8'h86, 1'b0},
    '{CMD_TICK,  4'd3,  16'd0,    16'd0,    8'd0,  16'd0,    1'b0, 8'h00, 1'b0},
    '{CMD_TICK,  4'd0,  16'd0,    16'd0,    8'd0,  16'd0,    1'b0, 8'h00, 1'b0},
    // two on periods, then a 30 ms pause, then the burst restarts
    '{CMD_FLASH, 4'd4,  16'd20,   16'd10,   8'd2,  16'd30,   1'b0, 8'h00, 1'b0},
    '{CMD_TICK,  4'd0,  16'd0,    16'd0,    8'd0,  16'd0,    1'b0, 8'h00, 1'b0},
    '{CMD_TICK,  4'd0,  16'd0,    16'd0,    8'd0,  16'd0,    1'b0, 8'h00, 1'b0},
    '{CMD_TICK,  4'd0,  16'd0,    16'd0,    8'd0,  16'd0,    1'b0, 8'h00, 1'b0},
    '{CMD_TICK,  4'd0,  16'd0,    16'd0,    8'd0,  16'd0,    1'b0, 8'h00, 1'b0},
    '{CMD_TICK,  4'd0,  16'd0,    16'd0,    8'd0,  16'd0,    1'b0, 8'h00, 1'b0},
    '{CMD_TICK,  4'd0,  16'd0,    16'd0,    8'd0,  16'd0,    1'b0, 8'h00, 1'b0},
    '{CMD_TICK,  4'd0,  16'd0,    16'd0,    8'd0,  16'd0,    1'b0, 8'h00, 1'b0},
    '{CMD_TICK,  4'd0,  16'd0,    16'd0,    8'd0,  16'd0,    1'b0, 8'h00, 1'b0},
    '{CMD_FLASH, 4'd5,  16'hFFFF, 16'd1,    8'd1,  16'd0,    1'b0, 8'h00, 1'b0},
    '{CMD_OFF,   4'd4,  16'h1234, 16'h5678, 8'h9A, 16'hBCDE, 1'b0, 8'h00, 1'b0},
    '{CMD_ON,    4'd2,  16'd0,    16'd0,    8'd0,  16'd0,    1'b0, 8'h00, 1'b0}
  };

  led_flash_pattern_timer uut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .command         (command),
    .led_number      (led_number),
    .on_time_ms      (on_time_ms),
    .off_time_ms     (off_time_ms),
    .cycle_limit     (cycle_limit),
    .repeat_delay_ms (repeat_delay_ms),
    .empty           (empty),
    .pop             (pop),
    .lit_mask        (lit_mask),
    .status          (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one tick applied to a single LED timer
  function automatic void tick_led_timer(int i);
    if (timers[i].remaining == 16'd0) return;
    if (timers[i].remaining > 16'(TICK_MS)) begin
      timers[i].remaining = timers[i].remaining - 16'(TICK_MS);
      return;
    end
    case (timers[i].phase)
      PH_ON: begin
        timers[i].lit       = 1'b0;
        timers[i].phase     = PH_OFF;
        timers[i].remaining = timers[i].off_p;
        if (timers[i].burst_len > 8'd0) begin
          timers[i].burst_cnt = timers[i].burst_cnt + 8'd1;
          if (timers[i].burst_cnt == timers[i].burst_len) begin
            if (timers[i].pause_p > 16'd0) begin
              timers[i].phase     = PH_PAUSE;
              timers[i].remaining = timers[i].pause_p;
            end else begin
              timers[i].remaining = '0;
            end
          end
        end
      end
      PH_OFF: begin
        timers[i].lit       = 1'b1;
        timers[i].phase     = PH_ON;
        timers[i].remaining = timers[i].on_p;
      end
      PH_PAUSE: begin
        timers[i].lit       = 1'b1;
        timers[i].phase     = PH_ON;
        timers[i].remaining = timers[i].on_p;
        timers[i].burst_cnt = '0;
      end
      default: ;
    endcase
  endfunction

  // updates the LED timers for one command, returns the lit mask and status
  function automatic lit_result_t apply_led_cmd(led_cmd_row_t c);
    lit_result_t r;
    int idx;
    r = '0;
    if (c.command == CMD_TICK) begin
      for (int i = 0; i < LED_COUNT; i++) tick_led_timer(i);
    end else if (int'(c.led_number) < 1 || int'(c.led_number) > LED_COUNT) begin
      r.status = 1'b1;
    end else begin
      idx = int'(c.led_number) - 1;
      timers[idx].remaining = '0;
      timers[idx].burst_cnt = '0;
      if (c.command == CMD_ON) begin
        timers[idx].phase   = PH_ON;
        timers[idx].pause_p = '0;
        timers[idx].lit     = 1'b1;
      end else if (c.command == CMD_OFF) begin
        timers[idx].phase   = PH_OFF;
        timers[idx].pause_p = '0;
        timers[idx].lit     = 1'b0;
      end else begin
        timers[idx].phase     = PH_ON;
        timers[idx].on_p      = c.on_ms;
        timers[idx].off_p     = c.off_ms;
        timers[idx].burst_len = c.cycles;
        timers[idx].pause_p   = c.delay_ms;
        timers[idx].remaining = c.on_ms;
        timers[idx].lit       = 1'b1;
      end
    end
    for (int i = 0; i < LED_COUNT && i < 8; i++) r.mask[i] = timers[i].lit;
    return r;
  endfunction

  // mostly short, well-formed patterns so bursts and pauses complete often;
  // a few full-range values and bad LED numbers mixed in
  function automatic led_cmd_row_t rand_led_cmd();
    led_cmd_row_t r;
    int sel;
    r = '0;
    sel = int'($urandom_range(99));
    r.led_number = 4'($urandom_range(15));
    r.on_ms      = 16'($urandom);
    r.off_ms     = 16'($urandom);
    r.cycles     = 8'($urandom);
    r.delay_ms   = 16'($urandom);
    if (sel < 50) begin
      r.command = CMD_TICK;
    end else begin
      r.command = (sel < 62) ? CMD_ON : (sel < 74) ? CMD_OFF : CMD_FLASH;
      if ($urandom_range(9) != 0) r.led_number = 4'($urandom_range(LED_COUNT, 1));
      if (r.command == CMD_FLASH && $urandom_range(19) != 0) begin
        r.on_ms    = 16'($urandom_range(60));
        r.off_ms   = 16'($urandom_range(60));
        r.cycles   = 8'($urandom_range(4));
        r.delay_ms = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(60, 10));
      end
    end
    return r;
  endfunction

  // push must already be driven once in this step only by this task
  task automatic send_led_cmd(led_cmd_row_t c);
    lit_result_t r;
    while (int'($urandom_range(99)) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push            <= 1'b1;
    command         <= c.command;
    led_number      <= c.led_number;
    on_time_ms      <= c.on_ms;
    off_time_ms     <= c.off_ms;
    cycle_limit     <= c.cycles;
    repeat_delay_ms <= c.delay_ms;
    do @(posedge clk); while (full);
    r = apply_led_cmd(c);
    if (c.fixed) r = {c.fixed_mask, c.fixed_status};
    lit_exp_q.push_back(r);
    n_cmds++;
    if (c.command == CMD_TICK) n_ticks++;
    else if (int'(c.led_number) < 1 || int'(c.led_number) > LED_COUNT) n_reject++;
    else if (c.command == CMD_FLASH) n_flash++;
  endtask

  task automatic wait_all_results();
    push <= 1'b0;
    @(posedge clk);
    while (lit_exp_q.size() != 0) @(posedge clk);
  endtask

  // result side: random pops, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      pop <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      pop <= (int'($urandom_range(99)) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      beats_checked++;
      if (lit_exp_q.size() == 0) begin
        $error("unexpected result beat: lit_mask %h status %b", lit_mask, status);
        errors++;
      end else begin
        lit_exp = lit_exp_q.pop_front();
        if (lit_mask !== lit_exp.mask) begin
          $error("lit_mask mismatch: expected %h, got %h", lit_exp.mask, lit_mask);
          errors++;
        end
        if (status !== lit_exp.status) begin
          $error("status mismatch: expected %b, got %b", lit_exp.status, status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, lit_exp_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) send_led_cmd(dir_rows[k]);
    wait_all_results();

    // sender idles 30%, receiver 87%, with one long receiver stall
    send_idle_pct = 30;
    recv_idle_pct = 87;
    for (int n = 0; n < 600; n++) begin
      if (n == 200) hold_requests++;
      send_led_cmd(rand_led_cmd());
    end
    wait_all_results();

    send_idle_pct = 87;
    recv_idle_pct = 30;
    for (int n = 0; n < 600; n++) send_led_cmd(rand_led_cmd());
    wait_all_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < 500; n++) send_led_cmd(rand_led_cmd());
    wait_all_results();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (lit_exp_q.size() != 0) begin
      $error("%0d expected results never arrived", lit_exp_q.size());
      errors++;
    end
    $display("Ran %0d commands: %0d ticks, %0d flash starts, %0d bad LED numbers.",
             n_cmds, n_ticks, n_flash, n_reject);
    $display("Checked %0d result beats across three idle mixes and a %0d-cycle stall.",
             beats_checked, HOLD_CYCLES);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
